// File: design/rnlt_pkg.sv
// package: constants, types and name masking for the named lock table
`default_nettype none
package rnlt_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned NameBytes  = 64;
  localparam int unsigned HoldBits   = 32;
  localparam int unsigned NameWords  = 8;
  localparam int unsigned SlotBits   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned WordBits   = $clog2(NameWords);
  localparam int unsigned NameAddrBits = SlotBits + WordBits;
  localparam int unsigned MetaBits   = 7 + 64 + HoldBits;

  typedef enum logic [2:0] {
    KIND_ACQUIRE = 3'd0, KIND_QFREE = 3'd1, KIND_QOWNER = 3'd2,
    KIND_RELEASE = 3'd3, KIND_RELALL = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_TOO_LONG = 3'd2,
    ST_FULL = 3'd3, ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_META, S_WORDS, S_NEXT, S_DECIDE, S_WRITE, S_DONE
  } state_e;

  typedef struct packed {
    logic [6:0]          len;
    logic [63:0]         owner;
    logic [HoldBits-1:0] holds;
  } meta_t;

  // keep only bytes below len in word w
  function automatic logic [63:0] mask_word(logic [6:0] len, logic [WordBits-1:0] w,
                                            logic [63:0] d);
    logic [63:0] m;
    logic [7:0]  start;
    logic [7:0]  kept;
    start = {5'd0, w} << 3;
    m = '0;
    if ({1'b0, len} > start) begin
      kept = {1'b0, len} - start;
      if (kept >= 8'd8) m = '1;
      else m = (64'd1 << {kept[2:0], 3'b000}) - 64'd1;
    end
    return d & m;
  endfunction
endpackage
`default_nettype wire

// File: design/rnlt_ram.sv
// generic single-port ram with registered read
`default_nettype none
module rnlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: design/recursive_named_lock_table.sv
// top level: recursive named lock table, sequential scan over slot memories
// the scan passes over a free slot in S_NEXT; a valid one has its metadata read in S_META and
//   its name words compared in S_WORDS; then S_DECIDE, S_WRITE (a fresh entry also writes
//   its name words) and S_DONE for output, and back to S_IDLE before the next item is taken
// one item at a time: no new item is taken until the block is back in S_IDLE
// reset: valid bits cleared at once (table empty), no clearing pass; control idle
`default_nettype none
module recursive_named_lock_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] requester_id_i,
  input  wire logic [6:0]  name_length_i,
  input  wire logic [63:0] name_word_0_i,
  input  wire logic [63:0] name_word_1_i,
  input  wire logic [63:0] name_word_2_i,
  input  wire logic [63:0] name_word_3_i,
  input  wire logic [63:0] name_word_4_i,
  input  wire logic [63:0] name_word_5_i,
  input  wire logic [63:0] name_word_6_i,
  input  wire logic [63:0] name_word_7_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic             answer_bit_o,
  output logic             is_null_o,
  output logic [63:0]      owner_id_o,
  output logic [63:0]      released_count_o
);
  localparam int unsigned SB = rnlt_pkg::SlotBits;
  localparam int unsigned WB = rnlt_pkg::WordBits;
  localparam int unsigned HB = rnlt_pkg::HoldBits;
  localparam int unsigned ND = rnlt_pkg::TableDepth;

  rnlt_pkg::state_e state_q, state_d;

  // latched request
  logic [2:0]  kind_q;
  logic [63:0] req_q;
  logic [6:0]  len_q;
  logic [63:0] words_q [rnlt_pkg::NameWords];

  logic [ND-1:0]  valid_q, valid_d;
  logic [SB:0]    slot_q, slot_d;     // one extra bit to reach the depth
  logic [WB:0]    word_q, word_d;
  logic           found_q, found_d;
  logic [SB-1:0]  hit_q, hit_d;
  rnlt_pkg::meta_t hit_meta_q, hit_meta_d;
  logic [63:0]    count_q, count_d;

  // result register
  logic        out_valid_q;
  logic [2:0]  status_q, status_d;
  logic        ans_q, ans_d, null_q, null_d;
  logic [63:0] own_q, own_d;

  // memory ports
  logic                          meta_we, name_we;
  logic [SB-1:0]                 meta_addr;
  logic [rnlt_pkg::NameAddrBits-1:0] name_addr;
  rnlt_pkg::meta_t               meta_wdata, meta_rdata;
  logic [63:0]                   name_wdata, name_rdata;

  rnlt_ram #(.Width(rnlt_pkg::MetaBits), .Depth(ND)) u_meta (
    .clk_i(clk_i), .we_i(meta_we), .addr_i(meta_addr),
    .wdata_i(meta_wdata), .rdata_o(meta_rdata));

  rnlt_ram #(.Width(64), .Depth(ND * rnlt_pkg::NameWords)) u_name (
    .clk_i(clk_i), .we_i(name_we), .addr_i(name_addr),
    .wdata_i(name_wdata), .rdata_o(name_rdata));

  logic accept_in, name_err, scan_kind, free_any;
  logic [SB-1:0] free_idx;
  logic [SB-1:0] slot_idx;
  logic [WB-1:0] word_idx;
  logic [64:0]   sum;

  assign accept_in = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != rnlt_pkg::S_IDLE);
  assign slot_idx = slot_q[SB-1:0];
  assign word_idx = word_q[WB-1:0];
  assign name_err = (len_q == 7'd0) || ({25'd0, len_q} > rnlt_pkg::NameBytes);
  assign scan_kind = (kind_q <= 3'(rnlt_pkg::KIND_RELALL));

  // lowest free slot from the valid flags
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ND - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SB'(i);
      end
    end
  end

  always_comb sum = {1'b0, count_q} + {{(65-HB){1'b0}}, meta_rdata.holds};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rnlt_pkg::S_IDLE: if (accept_in) state_d = rnlt_pkg::S_NEXT;
      rnlt_pkg::S_NEXT: begin
        if (!scan_kind || (kind_q != 3'(rnlt_pkg::KIND_RELALL) && name_err) || found_q
            || slot_q == (SB+1)'(ND))
          state_d = rnlt_pkg::S_DECIDE;
        else if (valid_q[slot_idx]) state_d = rnlt_pkg::S_META;
      end
      rnlt_pkg::S_META: begin
        if (kind_q == 3'(rnlt_pkg::KIND_RELALL) || meta_rdata.len != len_q)
          state_d = rnlt_pkg::S_NEXT;
        else state_d = rnlt_pkg::S_WORDS;
      end
      rnlt_pkg::S_WORDS: begin
        if (name_rdata != words_q[word_idx - WB'(1)] && word_q != '0)
          state_d = rnlt_pkg::S_NEXT;
        else if (word_q == (WB+1)'(rnlt_pkg::NameWords)) state_d = rnlt_pkg::S_DECIDE;
      end
      rnlt_pkg::S_DECIDE: state_d = rnlt_pkg::S_WRITE;
      rnlt_pkg::S_WRITE: begin
        if (kind_q == 3'(rnlt_pkg::KIND_ACQUIRE) && !found_q
            && word_q != (WB+1)'(rnlt_pkg::NameWords)
            && !name_err && status_q == rnlt_pkg::ST_OK && ans_q)
          state_d = rnlt_pkg::S_WRITE;
        else state_d = rnlt_pkg::S_DONE;
      end
      rnlt_pkg::S_DONE: if (!out_stall_i) state_d = rnlt_pkg::S_IDLE;
      default: state_d = rnlt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    valid_d = valid_q; slot_d = slot_q; word_d = word_q; found_d = found_q;
    hit_d = hit_q; hit_meta_d = hit_meta_q; count_d = count_q;
    status_d = status_q; ans_d = ans_q; null_d = null_q; own_d = own_q;
    meta_we = 1'b0; name_we = 1'b0;
    meta_addr = slot_idx;
    name_addr = {slot_idx, word_idx};
    meta_wdata = hit_meta_q;
    name_wdata = words_q[word_idx];
    case (state_q)
      rnlt_pkg::S_IDLE: begin
        slot_d = '0; word_d = '0; found_d = 1'b0; count_d = '0;
        status_d = rnlt_pkg::ST_OK; ans_d = 1'b0; null_d = 1'b0; own_d = '0;
      end
      rnlt_pkg::S_NEXT: begin
        word_d = '0;
        if (slot_q != (SB+1)'(ND) && !valid_q[slot_idx]) slot_d = slot_q + 1'b1;
      end
      rnlt_pkg::S_META: begin
        hit_meta_d = meta_rdata;
        if (kind_q == 3'(rnlt_pkg::KIND_RELALL)) begin
          if (meta_rdata.owner == req_q) begin
            count_d = sum[64] ? '1 : sum[63:0];
            valid_d[slot_idx] = 1'b0;
          end
          slot_d = slot_q + 1'b1;
        end else if (meta_rdata.len != len_q) begin
          slot_d = slot_q + 1'b1;
        end else begin
          word_d = (WB+1)'(1);
        end
      end
      rnlt_pkg::S_WORDS: begin
        if (word_q != '0 && name_rdata != words_q[word_idx - WB'(1)]) begin
          slot_d = slot_q + 1'b1;
          word_d = '0;
        end else if (word_q == (WB+1)'(rnlt_pkg::NameWords)) begin
          found_d = 1'b1;
          hit_d = slot_idx;
        end else begin
          word_d = word_q + 1'b1;
        end
      end
      rnlt_pkg::S_DECIDE: begin
        word_d = '0;
        if (kind_q == 3'(rnlt_pkg::KIND_RELEASE) || kind_q == 3'(rnlt_pkg::KIND_QOWNER))
          null_d = 1'b1;
        if (scan_kind && kind_q != 3'(rnlt_pkg::KIND_RELALL)) begin
          if (len_q == 7'd0) status_d = rnlt_pkg::ST_EMPTY;
          else if (name_err) status_d = rnlt_pkg::ST_TOO_LONG;
          else begin
            case (kind_q)
              3'(rnlt_pkg::KIND_ACQUIRE): begin
                if (!found_q) begin
                  if (!free_any) status_d = rnlt_pkg::ST_FULL;
                  else begin
                    ans_d = 1'b1;
                    hit_d = free_idx;
                    hit_meta_d = '{len: len_q, owner: req_q, holds: HB'(1)};
                  end
                end else if (hit_meta_q.owner == req_q) begin
                  if (hit_meta_q.holds == '1) status_d = rnlt_pkg::ST_OVERFLOW;
                  else begin
                    ans_d = 1'b1;
                    hit_meta_d.holds = hit_meta_q.holds + 1'b1;
                  end
                end
              end
              3'(rnlt_pkg::KIND_QFREE): ans_d = !found_q;
              3'(rnlt_pkg::KIND_QOWNER): begin
                if (found_q) begin null_d = 1'b0; own_d = hit_meta_q.owner; end
              end
              3'(rnlt_pkg::KIND_RELEASE): begin
                if (found_q) begin
                  null_d = 1'b0;
                  if (hit_meta_q.owner == req_q) begin
                    ans_d = 1'b1;
                    hit_meta_d.holds = hit_meta_q.holds - 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      rnlt_pkg::S_WRITE: begin
        meta_addr = hit_q;
        name_addr = {hit_q, word_idx};
        if (ans_q && (kind_q == 3'(rnlt_pkg::KIND_ACQUIRE)
                      || kind_q == 3'(rnlt_pkg::KIND_RELEASE))) begin
          if (word_q == '0) begin
            meta_we = 1'b1;
            if (kind_q == 3'(rnlt_pkg::KIND_RELEASE) && hit_meta_q.holds == '0)
              valid_d[hit_q] = 1'b0;
            if (kind_q == 3'(rnlt_pkg::KIND_ACQUIRE)) valid_d[hit_q] = 1'b1;
          end
          // a fresh entry also writes its eight name words
          if (kind_q == 3'(rnlt_pkg::KIND_ACQUIRE) && !found_q) begin
            name_we = 1'b1;
            word_d = word_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rnlt_pkg::S_IDLE;
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      out_valid_q <= (state_d == rnlt_pkg::S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      kind_q <= kind_i;
      req_q  <= requester_id_i;
      len_q  <= name_length_i;
      words_q[0] <= rnlt_pkg::mask_word(name_length_i, WB'(0), name_word_0_i);
      words_q[1] <= rnlt_pkg::mask_word(name_length_i, WB'(1), name_word_1_i);
      words_q[2] <= rnlt_pkg::mask_word(name_length_i, WB'(2), name_word_2_i);
      words_q[3] <= rnlt_pkg::mask_word(name_length_i, WB'(3), name_word_3_i);
      words_q[4] <= rnlt_pkg::mask_word(name_length_i, WB'(4), name_word_4_i);
      words_q[5] <= rnlt_pkg::mask_word(name_length_i, WB'(5), name_word_5_i);
      words_q[6] <= rnlt_pkg::mask_word(name_length_i, WB'(6), name_word_6_i);
      words_q[7] <= rnlt_pkg::mask_word(name_length_i, WB'(7), name_word_7_i);
    end
    slot_q <= slot_d; word_q <= word_d; found_q <= found_d; hit_q <= hit_d;
    hit_meta_q <= hit_meta_d; count_q <= count_d;
    status_q <= status_d; ans_q <= ans_d; null_q <= null_d; own_q <= own_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign answer_bit_o = ans_q;
  assign is_null_o = null_q;
  assign owner_id_o = own_q;
  assign released_count_o = count_q;

  // no item taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("item accepted with result pending");
  // a result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");
  // only valid slots match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rnlt_pkg::S_WORDS && state_d == rnlt_pkg::S_DECIDE) |-> valid_q[slot_idx])
    else $error("match on free slot");
endmodule
`default_nettype wire

// File: test/tb_recursive_named_lock_table.sv
// testbench: queue-fed driver, clocked monitor and predictor for the named lock table
`default_nettype none
module tb_recursive_named_lock_table;

  // kind codes the block ignores
  localparam logic [2:0] KindSpareFirst = 3'd5;
  localparam logic [2:0] KindSpareLast  = 3'd7;
  localparam int unsigned PoolSize = 20;
  localparam int unsigned ReqPool  = 4;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned QuietTail = 100;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] req;
    logic [6:0]  len;
    logic [63:0] w [rnlt_pkg::NameWords];
    bit          drain;
  } lock_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        answer;
    logic        is_null;
    logic [63:0] owner;
    logic [63:0] count;
  } lock_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  lock_result_t got;
  lock_req_t cur;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  recursive_named_lock_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(cur.kind), .requester_id_i(cur.req), .name_length_i(cur.len),
    .name_word_0_i(cur.w[0]), .name_word_1_i(cur.w[1]),
    .name_word_2_i(cur.w[2]), .name_word_3_i(cur.w[3]),
    .name_word_4_i(cur.w[4]), .name_word_5_i(cur.w[5]),
    .name_word_6_i(cur.w[6]), .name_word_7_i(cur.w[7]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(got.status), .answer_bit_o(got.answer), .is_null_o(got.is_null),
    .owner_id_o(got.owner), .released_count_o(got.count)
  );

  // shadow of the lock table
  bit          tbl_valid [rnlt_pkg::TableDepth];
  logic [63:0] tbl_words [rnlt_pkg::TableDepth][rnlt_pkg::NameWords];
  logic [6:0]  tbl_len   [rnlt_pkg::TableDepth];
  logic [63:0] tbl_owner [rnlt_pkg::TableDepth];
  logic [63:0] tbl_holds [rnlt_pkg::TableDepth];

  lock_req_t    pending_reqs [$];
  lock_result_t expected_results [$];
  int errors = 0;
  bit quiet = 1'b0;

  // name pool and requester pool
  logic [6:0]  pool_len [PoolSize];
  logic [63:0] pool_w   [PoolSize][rnlt_pkg::NameWords];
  logic [63:0] req_ids  [ReqPool];

  function automatic logic [63:0] keep_mask(logic [6:0] len, int w);
    int kept;
    kept = int'(len) - 8 * w;
    if (kept <= 0) return 64'd0;
    if (kept >= 8) return '1;
    return (64'd1 << (kept * 8)) - 64'd1;
  endfunction

  function automatic lock_result_t apply_lock_op(lock_req_t r);
    lock_result_t res;
    logic [63:0] nm [rnlt_pkg::NameWords];
    int hit, free_slot;
    bit same;
    res = '0;
    hit = -1;
    free_slot = -1;
    for (int w = 0; w < rnlt_pkg::NameWords; w++) nm[w] = r.w[w] & keep_mask(r.len, w);
    if (r.kind == rnlt_pkg::KIND_RELALL) begin
      for (int s = 0; s < rnlt_pkg::TableDepth; s++) begin
        if (tbl_valid[s] && tbl_owner[s] == r.req) begin
          if (res.count > ~64'd0 - tbl_holds[s]) res.count = '1;
          else res.count = res.count + tbl_holds[s];
          tbl_valid[s] = 1'b0;
        end
      end
    end else if (r.kind <= rnlt_pkg::KIND_RELEASE) begin
      res.is_null = (r.kind == rnlt_pkg::KIND_QOWNER || r.kind == rnlt_pkg::KIND_RELEASE);
      if (r.len == 0) res.status = rnlt_pkg::ST_EMPTY;
      else if (r.len > rnlt_pkg::NameBytes) res.status = rnlt_pkg::ST_TOO_LONG;
      else begin
        for (int s = 0; s < rnlt_pkg::TableDepth && hit < 0; s++) begin
          if (tbl_valid[s] && tbl_len[s] == r.len) begin
            same = 1'b1;
            for (int w = 0; w < rnlt_pkg::NameWords; w++)
              if (tbl_words[s][w] != nm[w]) same = 1'b0;
            if (same) hit = s;
          end
        end
        case (r.kind)
          rnlt_pkg::KIND_ACQUIRE: begin
            if (hit < 0) begin
              for (int t = 0; t < rnlt_pkg::TableDepth && free_slot < 0; t++)
                if (!tbl_valid[t]) free_slot = t;
              if (free_slot < 0) res.status = rnlt_pkg::ST_FULL;
              else begin
                tbl_valid[free_slot] = 1'b1;
                for (int w = 0; w < rnlt_pkg::NameWords; w++)
                  tbl_words[free_slot][w] = nm[w];
                tbl_len[free_slot] = r.len;
                tbl_owner[free_slot] = r.req;
                tbl_holds[free_slot] = 64'd1;
                res.answer = 1'b1;
              end
            end else if (tbl_owner[hit] == r.req) begin
              if (tbl_holds[hit] >= (64'd1 << rnlt_pkg::HoldBits) - 64'd1)
                res.status = rnlt_pkg::ST_OVERFLOW;
              else begin
                tbl_holds[hit] = tbl_holds[hit] + 64'd1;
                res.answer = 1'b1;
              end
            end
          end
          rnlt_pkg::KIND_QFREE: res.answer = (hit < 0);
          rnlt_pkg::KIND_QOWNER: if (hit >= 0) begin
            res.is_null = 1'b0;
            res.owner = tbl_owner[hit];
          end
          default: if (hit >= 0) begin
            res.is_null = 1'b0;
            if (tbl_owner[hit] == r.req) begin
              res.answer = 1'b1;
              tbl_holds[hit] = tbl_holds[hit] - 64'd1;
              if (tbl_holds[hit] == 0) tbl_valid[hit] = 1'b0;
            end
          end
        endcase
      end
    end
    return res;
  endfunction

  // build a request on pool name p; bytes past the length get random junk
  function automatic lock_req_t pool_req(logic [2:0] kind, int p, logic [63:0] req);
    lock_req_t r;
    r.kind = kind;
    r.req = req;
    r.len = pool_len[p];
    r.drain = 1'b0;
    for (int w = 0; w < rnlt_pkg::NameWords; w++)
      r.w[w] = pool_w[p][w] | ({$urandom, $urandom} & ~keep_mask(pool_len[p], w));
    return r;
  endfunction

  function automatic lock_req_t raw_req(logic [2:0] kind, logic [6:0] len, logic [63:0] req);
    lock_req_t r;
    r.kind = kind;
    r.req = req;
    r.len = len;
    r.drain = 1'b0;
    for (int w = 0; w < rnlt_pkg::NameWords; w++) r.w[w] = {$urandom, $urandom};
    return r;
  endfunction

  // driver: new item or gap at each falling edge once the previous one is taken
  bit took = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  always @(posedge clk_i) begin
    took <= rst_ni && in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) begin
      expected_results.push_back(apply_lock_op(cur));
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_reqs[0].drain && (expected_results.size() != 0 || in_valid)) begin
        // hold off until the block has answered everything
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 6);
      end else begin
        cur <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // result side: stall bursts and field checks
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      out_gap <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    lock_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item status=%0d answer=%0b null=%0b owner=%h count=%h",
                 $time, got.status, got.answer, got.is_null, got.owner, got.count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.answer !== want.answer) begin
          $display("%0t: answer_bit expected %0b got %0b", $time, want.answer, got.answer);
          errors++;
        end
        if (got.is_null !== want.is_null) begin
          $display("%0t: is_null expected %0b got %0b", $time, want.is_null, got.is_null);
          errors++;
        end
        if (got.owner !== want.owner) begin
          $display("%0t: owner_id expected %h got %h", $time, want.owner, got.owner);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: released_count expected %h got %h", $time, want.count, got.count);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    lock_req_t r;
    int roll, p;
    logic [63:0] id;
    cur = raw_req(rnlt_pkg::KIND_ACQUIRE, 7'd0, 64'd0);
    for (int s = 0; s < rnlt_pkg::TableDepth; s++) tbl_valid[s] = 1'b0;
    req_ids[0] = 64'd0;
    req_ids[1] = '1;
    req_ids[2] = {$urandom, $urandom};
    req_ids[3] = {$urandom, $urandom};
    for (int i = 0; i < PoolSize; i++) begin
      pool_len[i] = (i == 0) ? 7'd64 : (i == 1) ? 7'd1 : (i == 2) ? 7'd8
                    : 7'($urandom_range(1, rnlt_pkg::NameBytes));
      for (int w = 0; w < rnlt_pkg::NameWords; w++)
        pool_w[i][w] = (i == 0) ? '1 : {$urandom, $urandom} & keep_mask(pool_len[i], w);
      // first byte keeps pool names distinct
      if (i != 0) pool_w[i][0][7:0] = 8'(i + 1);
    end

    // directed: name errors on every kind but release-all, unused kinds
    for (int k = rnlt_pkg::KIND_ACQUIRE; k <= rnlt_pkg::KIND_RELEASE; k++) begin
      pending_reqs.push_back(raw_req(3'(k), 7'd0, req_ids[2]));
      pending_reqs.push_back(raw_req(3'(k), 7'd127, req_ids[2]));
    end
    pending_reqs.push_back(raw_req(rnlt_pkg::KIND_ACQUIRE, 7'd65, req_ids[1]));
    pending_reqs.push_back(raw_req(KindSpareFirst, 7'd5, req_ids[1]));
    pending_reqs.push_back(raw_req(KindSpareLast, 7'd64, req_ids[1]));
    // re-entry, foreign owner, queries, release
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_ACQUIRE, 0, req_ids[1]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_ACQUIRE, 0, req_ids[1]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_ACQUIRE, 0, req_ids[0]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_QFREE, 0, req_ids[0]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_QOWNER, 0, req_ids[0]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_RELEASE, 0, req_ids[0]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_RELEASE, 0, req_ids[1]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_QFREE, 1, req_ids[0]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_QOWNER, 1, req_ids[0]));
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_RELEASE, 1, req_ids[0]));
    // fill the table, the last two are refused, then drop everything
    for (int i = 1; i <= rnlt_pkg::TableDepth + 1; i++)
      pending_reqs.push_back(pool_req(rnlt_pkg::KIND_ACQUIRE, i, req_ids[3]));
    r = raw_req(rnlt_pkg::KIND_RELALL, 7'($urandom), req_ids[3]);
    r.drain = 1'b1;
    pending_reqs.push_back(r);
    pending_reqs.push_back(pool_req(rnlt_pkg::KIND_RELALL, 0, req_ids[1]));

    // random traffic on a small set of names and requesters
    for (int n = 0; n < RandomItems; n++) begin
      p = $urandom_range(0, PoolSize - 1);
      id = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
           : req_ids[$urandom_range(0, ReqPool - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 38) r = pool_req(rnlt_pkg::KIND_ACQUIRE, p, id);
      else if (roll < 46) r = pool_req(rnlt_pkg::KIND_QFREE, p, id);
      else if (roll < 58) r = pool_req(rnlt_pkg::KIND_QOWNER, p, id);
      else if (roll < 84) r = pool_req(rnlt_pkg::KIND_RELEASE, p, id);
      else if (roll < 89) r = raw_req(rnlt_pkg::KIND_RELALL, 7'($urandom), id);
      else if (roll < 93)
        r = raw_req(3'($urandom_range(rnlt_pkg::KIND_ACQUIRE, rnlt_pkg::KIND_RELEASE)),
                    7'($urandom_range(0, 1) ? 0 : $urandom_range(65, 127)), id);
      else if (roll < 97)
        r = raw_req(3'($urandom_range(rnlt_pkg::KIND_ACQUIRE, rnlt_pkg::KIND_RELEASE)),
                    7'($urandom_range(1, rnlt_pkg::NameBytes)), id);
      else r = raw_req(3'($urandom_range(KindSpareFirst, KindSpareLast)), 7'($urandom), id);
      if (n == RandomItems / 2) r.drain = 1'b1;
      pending_reqs.push_back(r);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_reqs.size() < QuietTail);
    quiet = 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
